>>> rtl/hks_pkg.sv
// shared types and constants for the hashed key set engine
// no dependencies; used by all rtl files through scoped names

package hks_pkg;

  // key field width and output tdata width
  localparam int unsigned KeyW      = 32;
  localparam int unsigned OutTDataW = 8;

  // the remainder unit splits its reciprocal constant at this bit
  localparam int unsigned RecipLoW = 16;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SQ_CLEAR,
    SQ_IDLE,
    SQ_HASH,
    SQ_FILL_RD,
    SQ_FILL_LD,
    SQ_SCAN,
    SQ_RESP
  } seq_state_e;

endpackage

>>> rtl/hks_mod_unit.sv
// iterative remainder unit: signed key modulo BUCKETS, taken non-negative
// depends on hks_pkg

module hks_mod_unit #(
  parameter int unsigned BUCKETS = 10,
  localparam int unsigned BW = $clog2(BUCKETS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [hks_pkg::KeyW-1:0] key_i,
  output logic                          done_o,
  output logic [BW-1:0]                 bucket_o
);

  localparam int unsigned RW    = BW + 1;
  localparam int unsigned Shift = hks_pkg::KeyW + BW;
  localparam int unsigned LoW   = hks_pkg::RecipLoW;
  localparam int unsigned HiW   = hks_pkg::KeyW + 1 - LoW;
  localparam int unsigned PW    = 2 * hks_pkg::KeyW + 1;

  // rounded-up reciprocal, exact quotient for every 32-bit magnitude
  localparam logic [63:0] Recip =
    ((64'd1 << Shift) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [HiW-1:0] RecipLo = HiW'(Recip[LoW-1:0]);
  localparam logic [HiW-1:0] RecipHi = Recip[LoW+HiW-1:LoW];

  // step codes
  localparam logic [1:0] StepLo  = 2'd0;
  localparam logic [1:0] StepHi  = 2'd1;
  localparam logic [1:0] StepRem = 2'd2;

  logic [hks_pkg::KeyW-1:0]     mag_q;
  logic                         neg_q;
  logic [PW-1:0]                acc_q;
  logic [HiW-1:0]               mul_b;
  logic [hks_pkg::KeyW+HiW-1:0] prod;
  logic [BW-1:0]                quo_lo, rem_raw, rem_q, rem_fix;
  logic [RW-1:0]                diff;
  logic [1:0]                   step_q;
  logic                         busy_q, fix_q, done_q;

  // one multiplier, fed the low then the high half of the reciprocal
  always_comb begin
    mul_b   = (step_q == StepLo) ? RecipLo : RecipHi;
    prod    = mag_q * mul_b;
    // remainder lies below BUCKETS, so its low bits are all that matter
    quo_lo  = acc_q[Shift +: BW];
    rem_raw = mag_q[BW-1:0] - BW'(quo_lo * BUCKETS);
    // sign correction: remainder takes the sign of the divisor
    diff    = RW'(BUCKETS) - {1'b0, rem_q};
    rem_fix = (neg_q && (rem_q != '0)) ? diff[BW-1:0] : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= StepLo;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepLo;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == StepRem) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= key_i[hks_pkg::KeyW-1];
      mag_q <= key_i[hks_pkg::KeyW-1] ? (~key_i + 1'b1) : key_i;
    end else if (busy_q) begin
      case (step_q)
        StepLo: begin
          acc_q <= PW'(prod);
        end
        StepHi: begin
          acc_q <= acc_q + (PW'(prod) << LoW);
        end
        default: begin
          rem_q <= rem_raw;
        end
      endcase
    end else if (fix_q) begin
      rem_q <= rem_fix;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

>>> rtl/hks_store.sv
// key slot memory and per-bucket fill count memory
// depends on hks_pkg

module hks_store #(
  parameter int unsigned BUCKETS          = 10,
  parameter int unsigned SLOTS_PER_BUCKET = 8,
  localparam int unsigned BW = $clog2(BUCKETS),
  localparam int unsigned FW = $clog2(SLOTS_PER_BUCKET + 1),
  localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1
) (
  input  logic                     clk_i,
  // fill counts, one address shared by read and write
  input  logic [BW-1:0]            fill_addr_i,
  input  logic                     fill_we_i,
  input  logic [FW-1:0]            fill_wdata_i,
  output logic [FW-1:0]            fill_rdata_o,
  // key slots of the selected bucket
  input  logic [BW-1:0]            slot_bkt_i,
  input  logic [SW-1:0]            slot_rd_idx_i,
  input  logic                     slot_we_i,
  input  logic [SW-1:0]            slot_wr_idx_i,
  input  logic [hks_pkg::KeyW-1:0] slot_wdata_i,
  output logic [hks_pkg::KeyW-1:0] slot_rdata_o
);

  localparam int unsigned Depth = BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [hks_pkg::KeyW-1:0] slot_mem [Depth];
  logic [FW-1:0]            fill_mem [BUCKETS];
  logic [AW-1:0]            base, rd_addr, wr_addr;

  // bucket base address: constant multiply of a narrow index
  assign base    = AW'(slot_bkt_i * SLOTS_PER_BUCKET);
  assign rd_addr = base + AW'(slot_rd_idx_i);
  assign wr_addr = base + AW'(slot_wr_idx_i);

  always_ff @(posedge clk_i) begin
    if (slot_we_i) begin
      slot_mem[wr_addr] <= slot_wdata_i;
    end
    slot_rdata_o <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we_i) begin
      fill_mem[fill_addr_i] <= fill_wdata_i;
    end
    fill_rdata_o <= fill_mem[fill_addr_i];
  end

endmodule

>>> rtl/hashed_key_set_engine_core.sv
// top level of the hashed key set engine: sequencer, slot compare, output register
// depends on hks_pkg, hks_mod_unit and hks_store

// Keeps a set of signed 32-bit keys in BUCKETS buckets of SLOTS_PER_BUCKET
// slots; a key lives in bucket (key mod BUCKETS), taken non-negative, so -1
// lands in the last bucket. Each input word inserts or searches one key and
// gives exactly one output word with a status code. An insert of a key that
// is already stored reports duplicate (even in a full bucket); an insert into
// a full bucket reports full and stores nothing. The block works on one word
// at a time: the wait from acceptance to the next ready grows with the
// number of occupied slots of the key's bucket, is shorter when a match is
// found early and longer while an earlier result still waits in the output
// register. The remainder unit does a reciprocal multiply in halves on one
// multiplier, forms the remainder, fixes the sign and hands the bucket off;
// then come one fill count read, one slot compare per occupied slot through
// a single memory read port and one commit.
// After reset the fill count memory is cleared, bucket by bucket, before the
// first input word is taken. A finished result sits in an output register,
// so the next word may enter while that result waits to be taken.

module hashed_key_set_engine_core #(
  parameter int unsigned BUCKETS          = 10,
  parameter int unsigned SLOTS_PER_BUCKET = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [hks_pkg::KeyW-1:0]       s_axis_tdata,   // [31:0] key (signed)
  input  logic                           s_axis_tuser,   // [0] operation
  // output words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [hks_pkg::OutTDataW-1:0]  m_axis_tdata    // [2:0] status, [7:3] zero
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

  hks_pkg::seq_state_e state_q, state_d;
  hks_pkg::op_e        op_q, op_d;
  logic [hks_pkg::KeyW-1:0] key_q, key_d;
  logic [BW-1:0]       bkt_q, bkt_d;
  logic [BW-1:0]       clr_q, clr_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [FW-1:0]       idx_q, idx_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic                hit_q, hit_d;
  logic                out_vld_q, out_vld_d;
  hks_pkg::status_e    out_status_q, out_status_d;

  logic                s_acc;
  logic                rd_issue;
  logic                out_load;
  hks_pkg::status_e    status;

  // memory and remainder unit hookup
  logic                mod_done;
  logic [BW-1:0]       mod_bucket;
  logic [BW-1:0]       fill_addr;
  logic                fill_we;
  logic [FW-1:0]       fill_wdata;
  logic [FW-1:0]       fill_rdata;
  logic                slot_we;
  logic [hks_pkg::KeyW-1:0] slot_rdata;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == hks_pkg::SQ_IDLE);

  hks_mod_unit #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (s_acc),
    .key_i    (s_axis_tdata),
    .done_o   (mod_done),
    .bucket_o (mod_bucket)
  );

  hks_store #(
    .BUCKETS          (BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_store (
    .clk_i         (clk_i),
    .fill_addr_i   (fill_addr),
    .fill_we_i     (fill_we),
    .fill_wdata_i  (fill_wdata),
    .fill_rdata_o  (fill_rdata),
    .slot_bkt_i    (bkt_q),
    .slot_rd_idx_i (idx_q[SW-1:0]),
    .slot_we_i     (slot_we),
    .slot_wr_idx_i (fill_q[SW-1:0]),
    .slot_wdata_i  (key_q),
    .slot_rdata_o  (slot_rdata)
  );

  // final status from the scan outcome and the bucket's fill count
  always_comb begin
    if (op_q == hks_pkg::OP_SEARCH) begin
      status = hit_q ? hks_pkg::ST_PRESENT : hks_pkg::ST_ABSENT;
    end else if (hit_q) begin
      status = hks_pkg::ST_DUPLICATE;
    end else if (fill_q == FW'(SLOTS_PER_BUCKET)) begin
      status = hks_pkg::ST_FULL;
    end else begin
      status = hks_pkg::ST_INSERTED;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    bkt_d      = bkt_q;
    clr_d      = clr_q;
    fill_d     = fill_q;
    idx_d      = idx_q;
    cmp_vld_d  = cmp_vld_q;
    hit_d      = hit_q;
    fill_addr  = bkt_q;
    fill_we    = 1'b0;
    fill_wdata = '0;
    slot_we    = 1'b0;
    rd_issue   = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      hks_pkg::SQ_CLEAR: begin
        // zero one fill count per cycle after reset
        fill_addr = clr_q;
        fill_we   = 1'b1;
        clr_d     = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = hks_pkg::SQ_IDLE;
        end
      end
      hks_pkg::SQ_IDLE: begin
        if (s_acc) begin
          op_d    = hks_pkg::op_e'(s_axis_tuser);
          key_d   = s_axis_tdata;
          state_d = hks_pkg::SQ_HASH;
        end
      end
      hks_pkg::SQ_HASH: begin
        if (mod_done) begin
          bkt_d   = mod_bucket;
          state_d = hks_pkg::SQ_FILL_RD;
        end
      end
      hks_pkg::SQ_FILL_RD: begin
        // fill count read issued at bkt_q
        state_d = hks_pkg::SQ_FILL_LD;
      end
      hks_pkg::SQ_FILL_LD: begin
        fill_d    = fill_rdata;
        idx_d     = '0;
        cmp_vld_d = 1'b0;
        hit_d     = 1'b0;
        state_d   = hks_pkg::SQ_SCAN;
      end
      hks_pkg::SQ_SCAN: begin
        // read one occupied slot a cycle, compare it the cycle after
        rd_issue  = (idx_q < fill_q);
        cmp_vld_d = rd_issue;
        if (rd_issue) begin
          idx_d = idx_q + FW'(1);
        end
        if (cmp_vld_q && (slot_rdata == key_q)) begin
          hit_d   = 1'b1;
          state_d = hks_pkg::SQ_RESP;
        end else if (!rd_issue && !cmp_vld_q) begin
          state_d = hks_pkg::SQ_RESP;
        end
      end
      hks_pkg::SQ_RESP: begin
        // wait for a free output register, then commit
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          if (status == hks_pkg::ST_INSERTED) begin
            slot_we    = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_q + FW'(1);
          end
          state_d = hks_pkg::SQ_IDLE;
        end
      end
      default: begin
        state_d = hks_pkg::SQ_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_status_d = out_status_q;
    if (out_load) begin
      out_vld_d    = 1'b1;
      out_status_d = status;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hks_pkg::SQ_CLEAR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    bkt_q        <= bkt_d;
    fill_q       <= fill_d;
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(hks_pkg::OutTDataW - 3){1'b0}}, out_status_q};

  // one word in flight: ready drops right after an acceptance
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while a word is in progress");

  // remainder unit finishes only while the sequencer waits for it
  a_mod_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == hks_pkg::SQ_HASH))
    else $error("remainder result outside of hash phase");

  // slots are written only for an insert of a key not found into a bucket with room
  a_slot_write_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_we |-> (op_q == hks_pkg::OP_INSERT) && !hit_q
                && (fill_q < FW'(SLOTS_PER_BUCKET)))
    else $error("slot write for a duplicate, a search or a full bucket");

  // a committed fill count grows by one and stays within the bucket
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_we && (state_q == hks_pkg::SQ_RESP)) |->
      (fill_wdata != '0) && (fill_wdata <= FW'(SLOTS_PER_BUCKET)))
    else $error("fill count written out of range");

  // the scan never reads past the occupied slots
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> (state_q == hks_pkg::SQ_SCAN) && (idx_q < fill_q))
    else $error("slot read beyond the fill count");

endmodule
